// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the nearest-node search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define NNS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante, outside reset.
`define NNS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/nns_pkg.sv
// Types, constants and codes shared by the nearest-node search modules.
package nns_pkg;

    // Table size default and the number of bank cells in the scan chain
    localparam int NNS_MAX_NODES = 1024;
    localparam int NNS_CELLS     = 4;
    localparam int NNS_CELL_W    = 2;

    // Field and datapath widths
    localparam int NNS_OP_W       = 2;
    localparam int NNS_COORD_W    = 20;
    localparam int NNS_DIFF_W     = 21;
    localparam int NNS_SQ_W       = 41;
    localparam int NNS_DIST_W     = 42;
    localparam int NNS_NODE_IDX_W = 10;
    localparam int NNS_IDX_W      = 16;
    localparam int NNS_ROW_W      = 14;

    // Opcodes
    localparam logic [NNS_OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [NNS_OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [NNS_OP_W-1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic [NNS_OP_W-1:0]           opcode;
        logic signed [NNS_COORD_W-1:0] point_x;
        logic signed [NNS_COORD_W-1:0] point_y;
    } nns_in_t;

    typedef struct packed {
        logic                          found;
        logic                          table_full;
        logic [NNS_NODE_IDX_W-1:0]     node_index;
        logic signed [NNS_COORD_W-1:0] near_x;
        logic signed [NNS_COORD_W-1:0] near_y;
        logic [NNS_DIST_W-1:0]         dist_sq;
    } nns_out_t;

    // Row request handed from cell to cell
    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic [NNS_ROW_W-1:0] addr;
    } nns_row_t;

    // Best candidate so far within one row, with the row's flags
    typedef struct packed {
        logic                          row_valid;
        logic                          row_last;
        logic                          hit;
        logic [NNS_IDX_W-1:0]          idx;
        logic signed [NNS_COORD_W-1:0] x;
        logic signed [NNS_COORD_W-1:0] y;
        logic [NNS_DIST_W-1:0]         dsq;
    } nns_best_t;

    typedef enum logic [1:0] {
        NNS_IDLE,
        NNS_ISSUE,
        NNS_WAIT,
        NNS_FINISH
    } nns_state_t;

endpackage

// File: hw/rtl/nns_cell.sv
// One bank cell of the scan chain: holds every fourth node and compares its candidate.
module nns_cell import nns_pkg::*; #(
    parameter int MAX_NODES = NNS_MAX_NODES,
    localparam int DEPTH = (MAX_NODES + NNS_CELLS - 1) / NNS_CELLS,
    localparam int ROW_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(MAX_NODES + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [NNS_CELL_W-1:0]         cell_id,
    input  logic [CNT_W-1:0]              node_count,
    input  logic signed [NNS_COORD_W-1:0] query_x,
    input  logic signed [NNS_COORD_W-1:0] query_y,
    input  logic                          wr_en,
    input  logic [ROW_W-1:0]              wr_addr,
    input  logic signed [NNS_COORD_W-1:0] wr_x,
    input  logic signed [NNS_COORD_W-1:0] wr_y,
    input  nns_row_t                      row_in,
    output nns_row_t                      row_out,
    input  nns_best_t                     best_in,
    output nns_best_t                     best_out
);

    logic signed [NNS_COORD_W-1:0] mem_x [DEPTH];
    logic signed [NNS_COORD_W-1:0] mem_y [DEPTH];

    nns_row_t                      row0_reg;
    logic                          valid1_reg, valid2_reg;
    logic                          last1_reg, last2_reg;
    logic                          hit1_reg, hit2_reg;
    logic [NNS_IDX_W-1:0]          idx1_reg, idx2_reg;
    logic signed [NNS_COORD_W-1:0] rx1_reg, ry1_reg, rx2_reg, ry2_reg;
    logic [NNS_SQ_W-1:0]           sqx2_reg, sqy2_reg;
    nns_best_t                     best_reg, best_next;

    logic [NNS_IDX_W-1:0]          cand;
    logic                          cand_hit;
    logic signed [NNS_DIFF_W-1:0]  dx, dy;
    logic signed [NNS_DIST_W-1:0]  px, py;
    logic [NNS_DIST_W-1:0]         cand_dist;

    // Node index of this cell's entry in the current row
    assign cand     = NNS_IDX_W'({row0_reg.addr[ROW_W-1:0], cell_id});
    assign cand_hit = row0_reg.valid && (32'(cand) < 32'(node_count));

    // Squares of the coordinate differences
    assign dx = NNS_DIFF_W'(query_x) - NNS_DIFF_W'(rx1_reg);
    assign dy = NNS_DIFF_W'(query_y) - NNS_DIFF_W'(ry1_reg);
    assign px = dx * dx;
    assign py = dy * dy;

    // Advance the row request and the control flags of the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row0_reg   <= '0;
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            last1_reg  <= 1'b0;
            last2_reg  <= 1'b0;
        end else begin
            row0_reg   <= row_in;
            valid1_reg <= row0_reg.valid;
            valid2_reg <= valid1_reg;
            last1_reg  <= row0_reg.last;
            last2_reg  <= last1_reg;
        end
    end

    // Bank storage: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
        end
        rx1_reg <= mem_x[row0_reg.addr[ROW_W-1:0]];
        ry1_reg <= mem_y[row0_reg.addr[ROW_W-1:0]];
    end

    // Advance the payload of the pipeline
    always_ff @(posedge aclk) begin
        hit1_reg      <= cand_hit;
        idx1_reg      <= cand;
        hit2_reg      <= hit1_reg;
        idx2_reg      <= idx1_reg;
        rx2_reg       <= rx1_reg;
        ry2_reg       <= ry1_reg;
        sqx2_reg      <= px[NNS_SQ_W-1:0];
        sqy2_reg      <= py[NNS_SQ_W-1:0];
    end

    // Keep the incoming best unless this entry is strictly closer
    always_comb begin
        cand_dist           = {1'b0, sqx2_reg} + {1'b0, sqy2_reg};
        best_next           = best_in;
        best_next.row_valid = valid2_reg;
        best_next.row_last  = last2_reg;
        best_next.hit       = best_in.hit && valid2_reg;
        if (valid2_reg && hit2_reg && (!best_in.hit || cand_dist < best_in.dsq)) begin
            best_next.hit = 1'b1;
            best_next.idx = idx2_reg;
            best_next.x   = rx2_reg;
            best_next.y   = ry2_reg;
            best_next.dsq = cand_dist;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg <= '0;
        end else begin
            best_reg <= best_next;
        end
    end

    assign row_out  = row0_reg;
    assign best_out = best_reg;

endmodule

// File: hw/rtl/nearest_node_search.sv
// Top level of the nearest-node search: sequencer, node count and the chain of bank cells.
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    s_item  (opcode, point_x, point_y)
//   m_        out        m_valid / m_ready    m_item  (found .. dist_sq)
//
// Clear, append and unused opcodes, and a query on an empty table, go straight from accept to the finish state.
// In a query, four bank cells each read one
// entry per cycle through their single read port, then the chain drains.
// Reset (aresetn low, synchronous) empties the table; node storage is not cleared.
// The next item is accepted while a result still waits in the output register.
`include "assert_macros.svh"

module nearest_node_search import nns_pkg::*; #(
    parameter int MAX_NODES = NNS_MAX_NODES,
    localparam int DEPTH = (MAX_NODES + NNS_CELLS - 1) / NNS_CELLS,
    localparam int ROW_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(MAX_NODES + 1)
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  nns_in_t  s_item,
    output logic     m_valid,
    input  logic     m_ready,
    output nns_out_t m_item
);

    nns_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ROW_W-1:0] row_reg, last_row;
    logic signed [NNS_COORD_W-1:0] qx_reg, qy_reg;
    nns_best_t acc_reg, acc_next;
    nns_out_t res_reg, res_next;
    logic m_valid_reg;
    nns_out_t m_item_reg;

    logic accept, full, out_load, tail_done;
    logic wr_en;
    logic [CNT_W-1:0] wr_index;
    logic [NNS_CELL_W-1:0] wr_bank;
    logic [ROW_W-1:0] wr_row;
    nns_row_t issue_row;

    nns_row_t  chain_row  [NNS_CELLS+1];
    nns_best_t chain_best [NNS_CELLS+1];

    assign accept   = s_valid && s_ready;
    assign full     = (cnt_reg == CNT_W'(MAX_NODES));
    assign last_row = ROW_W'((cnt_reg - 1'b1) >> NNS_CELL_W);
    assign tail_done = chain_best[NNS_CELLS].row_valid && chain_best[NNS_CELLS].row_last;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            NNS_IDLE: begin
                if (accept) begin
                    if (s_item.opcode == OP_QUERY && cnt_reg != '0) begin
                        state_next = NNS_ISSUE;
                    end else begin
                        state_next = NNS_FINISH;
                    end
                end
            end
            NNS_ISSUE: begin
                if (row_reg == last_row) begin
                    state_next = NNS_WAIT;
                end
            end
            NNS_WAIT: begin
                if (tail_done) begin
                    state_next = NNS_FINISH;
                end
            end
            NNS_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = NNS_IDLE;
                end
            end
            default: begin
                state_next = NNS_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready         = 1'b0;
        out_load        = 1'b0;
        issue_row.valid = 1'b0;
        issue_row.last  = 1'b0;
        issue_row.addr  = NNS_ROW_W'(row_reg);
        case (state_reg)
            NNS_IDLE: begin
                s_ready = 1'b1;
            end
            NNS_ISSUE: begin
                issue_row.valid = 1'b1;
                issue_row.last  = (row_reg == last_row);
            end
            NNS_WAIT: begin
                s_ready = 1'b0;
            end
            NNS_FINISH: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Table writes for clear and append
    assign wr_en    = accept && (s_item.opcode == OP_CLEAR || (s_item.opcode == OP_APPEND && !full));
    assign wr_index = (s_item.opcode == OP_CLEAR) ? '0 : cnt_reg;
    assign wr_bank  = NNS_CELL_W'(wr_index);
    assign wr_row   = ROW_W'(wr_index >> NNS_CELL_W);

    // Node count
    always_comb begin
        cnt_next = cnt_reg;
        if (accept && s_item.opcode == OP_CLEAR) begin
            cnt_next = CNT_W'(1);
        end else if (accept && s_item.opcode == OP_APPEND && !full) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // Merge each row's best into the query's best, lower rows first
    always_comb begin
        acc_next = acc_reg;
        if (chain_best[NNS_CELLS].row_valid && chain_best[NNS_CELLS].hit &&
            (!acc_reg.hit || chain_best[NNS_CELLS].dsq < acc_reg.dsq)) begin
            acc_next = chain_best[NNS_CELLS];
        end
    end

    // Pending result: set on accept, filled in when the scan finishes
    always_comb begin
        res_next = res_reg;
        if (accept) begin
            res_next            = '0;
            res_next.found      = wr_en;
            res_next.table_full = (s_item.opcode == OP_APPEND) && full;
            if (s_item.opcode == OP_APPEND && !full) begin
                res_next.node_index = NNS_NODE_IDX_W'(cnt_reg);
            end
        end else if (state_reg == NNS_WAIT && tail_done) begin
            res_next.found      = acc_next.hit;
            res_next.table_full = 1'b0;
            res_next.node_index = NNS_NODE_IDX_W'(acc_next.idx);
            res_next.near_x     = acc_next.x;
            res_next.near_y     = acc_next.y;
            res_next.dist_sq    = acc_next.dsq;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= NNS_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Query point, row counter, best so far and the pending result
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (accept) begin
            qx_reg  <= s_item.point_x;
            qy_reg  <= s_item.point_y;
            row_reg <= '0;
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
            if (state_reg == NNS_ISSUE) begin
                row_reg <= row_reg + 1'b1;
            end
        end
        if (out_load) begin
            m_item_reg <= res_reg;
        end
    end

    // Chain of bank cells
    assign chain_row[0]  = issue_row;
    assign chain_best[0] = '0;

    for (genvar k = 0; k < NNS_CELLS; k++) begin : g_cell
        nns_cell #(
            .MAX_NODES (MAX_NODES)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_id    (NNS_CELL_W'(k)),
            .node_count (cnt_reg),
            .query_x    (qx_reg),
            .query_y    (qy_reg),
            .wr_en      (wr_en && (wr_bank == NNS_CELL_W'(k))),
            .wr_addr    (wr_row),
            .wr_x       (s_item.point_x),
            .wr_y       (s_item.point_y),
            .row_in     (chain_row[k]),
            .row_out    (chain_row[k+1]),
            .best_in    (chain_best[k]),
            .best_out   (chain_best[k+1])
        );
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Checks
    `NNS_ASSERT_IMPL(a_idle_chain_empty, s_ready, !chain_row[NNS_CELLS].valid && !chain_best[NNS_CELLS].row_valid, "item taken while a scan is still in the chain")
    `NNS_ASSERT_IMPL(a_scan_nonempty, state_reg == NNS_ISSUE, cnt_reg != '0, "scan issued over an empty table")
    `NNS_ASSERT_IMPL(a_count_bound, 1'b1, 32'(cnt_reg) <= 32'(MAX_NODES), "node count above table size")
    `NNS_ASSERT_NEXT(a_refused_keeps_count, accept && s_item.opcode == OP_APPEND && full, cnt_reg == $past(cnt_reg), "refused append changed the node count")

endmodule
